>>> sv/cda_pkg.sv
// ----------------------------------------------------------------------------
// cda_pkg: shared types and constants of the calendar date adder
// Payload structs, request and status codes, month lengths and calendar helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package cda_pkg;

    localparam int YEAR_W  = 15;
    localparam int AMT_W   = 15;
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int REQ_W   = 3;
    localparam int STAT_W  = 2;

    // divider works on one bit more than a year so that sums fit
    localparam int DIV_W  = YEAR_W + 1;
    localparam int REM_W  = 9;
    localparam int DAYS_W = AMT_W + 3;

    localparam logic [REM_W-1:0] DIV_YEAR  = 9'd400;
    localparam logic [REM_W-1:0] DIV_MONTH = 9'd12;
    localparam logic [REM_W-1:0] R400_LAST = 9'd399;

    // quotient is (x * recip) >> shift, exact for every 16-bit x
    localparam int REC_W       = 17;
    localparam int PROD_W      = DIV_W + REC_W;
    localparam int SHIFT_MONTH = 20;
    localparam int SHIFT_YEAR  = 25;

    localparam logic [REC_W-1:0] RECIP_MONTH = 17'd87382;
    localparam logic [REC_W-1:0] RECIP_YEAR  = 17'd83887;

    localparam logic [REQ_W-1:0] REQ_DAYS    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_WEEKS   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_MONTHS  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_YSTEP   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_YDIRECT = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_INVALID  = 2'd1;
    localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd2;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [AMT_W-1:0]   amount;
        logic [DAY_W-1:0]   day_in;
        logic [MONTH_W-1:0] month_in;
        logic [YEAR_W-1:0]  year_in;
    } t_cda_in;

    typedef struct packed {
        logic [DAY_W-1:0]   day_out;
        logic [MONTH_W-1:0] month_out;
        logic [YEAR_W-1:0]  year_out;
        logic [STAT_W-1:0]  status;
    } t_cda_out;

    typedef struct packed {
        logic start;
        logic by_year;
    } t_cda_div_ctl;

    // leap from the two low year bits and the year modulo 400
    function automatic logic cda_leap(input logic [1:0] y_low, input logic [REM_W-1:0] r400);
        return (y_low == 2'd0) && (r400 != 9'd100) && (r400 != 9'd200) && (r400 != 9'd300);
    endfunction

    function automatic logic [DAY_W-1:0] cda_days_in(input logic [MONTH_W-1:0] month,
                                                     input logic leap);
        logic [DAY_W-1:0] len;
        len = 5'd31;
        if (month == MONTH_FEB) begin
            len = leap ? 5'd29 : 5'd28;
        end else if (month >= MONTH_JAN && month <= MONTH_DEC) begin
            len = MONTH_LEN[month - 4'd1];
        end
        return len;
    endfunction

endpackage

`default_nettype wire

>>> sv/cda_div.sv
// ----------------------------------------------------------------------------
// cda_div: shared constant divider
// Divides a 16-bit value by 12 or by 400 by reciprocal multiplication.
// ----------------------------------------------------------------------------
`default_nettype none

module cda_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire cda_pkg::t_cda_div_ctl         i_ctl,
    input  wire logic [cda_pkg::DIV_W-1:0]     i_dividend,
    output logic                               o_done,
    output logic [cda_pkg::DIV_W-1:0]          o_quo,
    output logic [cda_pkg::REM_W-1:0]          o_rem
);
    import cda_pkg::*;

    logic                r_mul_vld;
    logic                r_quo_vld;
    logic                r_done;
    logic                r_by_year;
    logic [DIV_W-1:0]    r_arg;
    logic [PROD_W-1:0]   r_prod;
    logic [DIV_W-1:0]    r_quo;
    logic [REM_W-1:0]    r_rem;

    logic [REC_W-1:0]    w_recip;
    logic [DIV_W-1:0]    w_quo;
    logic [DIV_W-1:0]    w_back;
    logic [DIV_W-1:0]    w_diff;

    always_comb begin
        w_recip = i_ctl.by_year ? RECIP_YEAR : RECIP_MONTH;
        w_quo   = r_by_year ? DIV_W'(r_prod >> SHIFT_YEAR) : DIV_W'(r_prod >> SHIFT_MONTH);
        // quotient times divisor never exceeds the dividend
        w_back  = r_by_year ? r_quo * DIV_W'(DIV_YEAR) : r_quo * DIV_W'(DIV_MONTH);
        w_diff  = r_arg - w_back;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_vld <= 1'b0;
            r_quo_vld <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_mul_vld <= i_ctl.start;
            r_quo_vld <= r_mul_vld;
            r_done    <= r_quo_vld;
            if (i_ctl.start) begin
                r_arg     <= i_dividend;
                r_by_year <= i_ctl.by_year;
                r_prod    <= {{REC_W{1'b0}}, i_dividend} * {{DIV_W{1'b0}}, w_recip};
            end
            if (r_mul_vld) begin
                r_quo <= w_quo;
            end
            if (r_quo_vld) begin
                r_rem <= w_diff[REM_W-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

>>> sv/calendar_date_adder_top.sv
// ----------------------------------------------------------------------------
// calendar_date_adder_top: Gregorian date adder
// Adds days, weeks, months or years to a date under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_in_valid / o_in_stall with i_in_data. A beat is taken when
//   valid is high and stall low. o_in_stall is high while an item is in work.
//   Output channel: o_out_valid / i_out_stall with o_out_data, one result beat
//   per input beat, held in an output register while the receiver stalls.
//   Sequence: the year modulo 400 is found first by a shared divider that
//   multiplies by a reciprocal. Days and weeks then step through the months,
//   one month boundary at a time, before the result beat is offered. Months
//   divide by 12, then find the modulo 400 of the new year; years find the
//   modulo 400 of the new year (a zero year step skips it); invalid dates and
//   unknown requests go straight to the result.
//   The next beat is taken in the cycle after the result is loaded, even when
//   the previous result still waits in the output register; a result that
//   cannot be loaded because the receiver stalls holds the sequencer.
//   Reset (synchronous, active low) empties the output register and returns
//   the sequencer to idle; no memory needs clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_date_adder_top (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire cda_pkg::t_cda_in    i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output cda_pkg::t_cda_out        o_out_data
);
    import cda_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_VDIV, S_CHECK, S_DAYS, S_MDIV, S_YDIV, S_CLAMP, S_FIN
    } t_state;

    t_state              r_state;
    logic [REQ_W-1:0]    r_req;
    logic [AMT_W-1:0]    r_amt;
    logic [DAY_W-1:0]    r_d0;
    logic [MONTH_W-1:0]  r_m0;
    logic [YEAR_W-1:0]   r_y0;
    logic [DAY_W-1:0]    r_d;
    logic [DAY_W-1:0]    r_dmid;
    logic [MONTH_W-1:0]  r_m;
    logic [DIV_W-1:0]    r_y;
    logic [REM_W-1:0]    r_r400;
    logic [DAYS_W-1:0]   r_n;
    logic [STAT_W-1:0]   r_status;
    logic                r_out_valid;
    t_cda_out            r_out;
    t_cda_div_ctl        r_div_ctl;
    logic [DIV_W-1:0]    r_div_arg;

    logic                w_div_done;
    logic [DIV_W-1:0]    w_div_quo;
    logic [REM_W-1:0]    w_div_rem;

    logic                w_out_free;
    logic                w_leap;
    logic [DAY_W-1:0]    w_dim;
    logic [DAY_W-1:0]    w_to_end;
    logic                w_valid_date;
    logic [REM_W-1:0]    w_r400_next;
    logic                w_leap_next;
    logic [DIV_W-1:0]    w_y_plus_amt;
    logic [DIV_W-1:0]    w_month_idx;
    logic [DAYS_W-1:0]   w_weeks;

    cda_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (r_div_ctl),
        .i_dividend (r_div_arg),
        .o_done     (w_div_done),
        .o_quo      (w_div_quo),
        .o_rem      (w_div_rem)
    );

    always_comb begin
        w_out_free   = !r_out_valid || !i_out_stall;
        w_leap       = cda_leap(r_y[1:0], r_r400);
        w_dim        = cda_days_in(r_m, w_leap);
        w_to_end     = w_dim - r_d;
        w_valid_date = (r_m0 >= MONTH_JAN) && (r_m0 <= MONTH_DEC) && (r_d0 != '0)
                       && (r_d0 <= cda_days_in(r_m0, w_leap));
        // year plus one, tracked without a divide
        w_r400_next  = (r_r400 == R400_LAST) ? '0 : r_r400 + 1'b1;
        w_leap_next  = cda_leap(r_y[1:0] + 2'd1, w_r400_next);
        w_y_plus_amt = {1'b0, r_y0} + {1'b0, r_amt};
        w_month_idx  = {12'd0, r_m0} - 16'd1 + {1'b0, r_amt};
        w_weeks      = {r_amt, 3'b000} - {3'b000, r_amt};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_div_ctl   <= '0;
        end else begin
            r_div_ctl.start <= 1'b0;
            if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_req             <= i_in_data.req_type;
                        r_amt             <= i_in_data.amount;
                        r_d0              <= i_in_data.day_in;
                        r_m0              <= i_in_data.month_in;
                        r_y0              <= i_in_data.year_in;
                        r_status          <= ST_OK;
                        r_div_arg         <= {1'b0, i_in_data.year_in};
                        r_div_ctl.start   <= 1'b1;
                        r_div_ctl.by_year <= 1'b1;
                        r_state           <= S_VDIV;
                    end
                end
                S_VDIV: begin
                    if (w_div_done) begin
                        r_r400  <= w_div_rem;
                        r_y     <= {1'b0, r_y0};
                        r_d     <= r_d0;
                        r_dmid  <= r_d0;
                        r_m     <= r_m0;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (!w_valid_date) begin
                        r_status <= ST_INVALID;
                        r_state  <= S_FIN;
                    end else begin
                        case (r_req)
                            REQ_DAYS: begin
                                r_n     <= {3'b000, r_amt};
                                r_state <= S_DAYS;
                            end
                            REQ_WEEKS: begin
                                r_n     <= w_weeks;
                                r_state <= S_DAYS;
                            end
                            REQ_MONTHS: begin
                                r_div_arg         <= w_month_idx;
                                r_div_ctl.start   <= 1'b1;
                                r_div_ctl.by_year <= 1'b0;
                                r_state           <= S_MDIV;
                            end
                            REQ_YSTEP: begin
                                if (r_amt != '0) begin
                                    // the first step decides the running day
                                    r_dmid <= (r_d0 > cda_days_in(r_m0, w_leap_next))
                                              ? cda_days_in(r_m0, w_leap_next) : r_d0;
                                    r_y               <= w_y_plus_amt;
                                    r_div_arg         <= w_y_plus_amt;
                                    r_div_ctl.start   <= 1'b1;
                                    r_div_ctl.by_year <= 1'b1;
                                    r_state           <= S_YDIV;
                                end else begin
                                    r_state <= S_FIN;
                                end
                            end
                            REQ_YDIRECT: begin
                                r_y               <= w_y_plus_amt;
                                r_div_arg         <= w_y_plus_amt;
                                r_div_ctl.start   <= 1'b1;
                                r_div_ctl.by_year <= 1'b1;
                                r_state           <= S_YDIV;
                            end
                            default: begin
                                r_state <= S_FIN;
                            end
                        endcase
                    end
                end
                S_DAYS: begin
                    // one month per cycle
                    if (r_n <= {13'd0, w_to_end}) begin
                        r_d     <= r_d + r_n[DAY_W-1:0];
                        r_n     <= '0;
                        r_state <= S_FIN;
                    end else begin
                        r_n <= r_n - ({13'd0, w_to_end} + 18'd1);
                        r_d <= 5'd1;
                        if (r_m == MONTH_DEC) begin
                            r_m    <= MONTH_JAN;
                            r_y    <= r_y + 1'b1;
                            r_r400 <= w_r400_next;
                        end else begin
                            r_m <= r_m + 1'b1;
                        end
                    end
                end
                S_MDIV: begin
                    if (w_div_done) begin
                        r_m               <= w_div_rem[MONTH_W-1:0] + 1'b1;
                        r_y               <= {1'b0, r_y0} + w_div_quo;
                        r_div_arg         <= {1'b0, r_y0} + w_div_quo;
                        r_div_ctl.start   <= 1'b1;
                        r_div_ctl.by_year <= 1'b1;
                        r_state           <= S_YDIV;
                    end
                end
                S_YDIV: begin
                    if (w_div_done) begin
                        r_r400  <= w_div_rem;
                        r_state <= S_CLAMP;
                    end
                end
                S_CLAMP: begin
                    r_d     <= (r_dmid > w_dim) ? w_dim : r_dmid;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        if (r_status == ST_INVALID || r_y[DIV_W-1]) begin
                            r_out.day_out   <= r_d0;
                            r_out.month_out <= r_m0;
                            r_out.year_out  <= r_y0;
                            r_out.status    <= (r_status == ST_INVALID) ? ST_INVALID
                                                                        : ST_OVERFLOW;
                        end else begin
                            r_out.day_out   <= r_d;
                            r_out.month_out <= r_m;
                            r_out.year_out  <= r_y[YEAR_W-1:0];
                            r_out.status    <= ST_OK;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire
